@@ sv/pdjb_pkg.sv @@
// Package for the payload deframer and jitter buffer.
// Holds store geometry, result codes, marker characters and the stage record.
// No dependencies.
`default_nettype none

package pdjb_pkg;

    localparam int STORE_DEPTH = 8192;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CFG_W       = 13;
    localparam int FILL_W      = 13;
    localparam int CMP_W       = (ADDR_W > CFG_W) ? ADDR_W : CFG_W;

    localparam logic [1:0] CFG_START_THR = 2'd0;
    localparam logic [1:0] CFG_MAX_OCC   = 2'd1;
    localparam logic [1:0] CFG_FADE_KEEP = 2'd2;

    localparam logic [12:0] START_THR_RST = 13'd1200;
    localparam logic [12:0] MAX_OCC_RST   = 13'd7000;
    localparam logic [8:0]  FADE_KEEP_RST = 9'd253;
    localparam logic [8:0]  FADE_FULL     = 9'd256;
    localparam logic [11:0] MID_LEVEL     = 12'd2048;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    typedef enum logic [1:0] {
        KIND_SILENT = 2'd0,
        KIND_CTRL   = 2'd1,
        KIND_SAMPLE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        SMP_STORE = 2'd0,
        SMP_FADE  = 2'd1,
        SMP_MID   = 2'd2
    } t_smode;

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        ctrl;
        logic              strip;
        t_smode            smode;
        logic              dropped;
        logic [FILL_W-1:0] fill;
    } t_s2;

    function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
        logic [ADDR_W-1:0] r;
        if (p == ADDR_W'(STORE_DEPTH - 1)) r = '0;
        else r = p + ADDR_W'(1);
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

endpackage

`default_nettype wire

@@ sv/pdjb_ram.sv @@
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Read data holds until the next read enable. No dependencies.
`default_nettype none

module pdjb_ram #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/payload_deframer_jitter_buffer.sv @@
// Top level of the payload deframer and jitter buffer.
// Depends on pdjb_pkg and pdjb_ram.
//
// Usage: the input channel carries one beat per modem byte (func = 0) or per
// playback tick (func = 1), together with the current call state. Every input
// beat produces exactly one output beat: a silently consumed byte, a control
// byte for the line store (with a strip flag on the byte that completes the
// "+IPD" marker), or a 12-bit DAC sample. Each output beat also reports the
// ring occupancy and whether the latency cap dropped the oldest byte.
//
// Throughput is one beat per cycle while the receiver keeps up. The first
// stage decodes the byte, updates the framing state and pointers and issues
// the store access; the second stage takes the registered store read data,
// computes the sample (read, fade multiply or mid-scale) and loads the output
// register. An accepted beat passes through the stage-two register and then
// the output register, where it waits for the receiver. When the receiver
// stalls, the output register holds and the second stage fills; input ready
// then drops until the output beat is taken.
//
// Reset clears framing state, pointers, fill count and both pipeline valids,
// restores the register defaults and sets the last level to mid-scale. The
// store itself is not cleared. Configuration writes are taken at any cycle;
// the fade weight is applied in the second stage, so writes belong where no
// beat is in flight.
`default_nettype none

module payload_deframer_jitter_buffer
    import pdjb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    // input channel
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_func,
    input  wire logic [7:0]        i_rx_byte,
    input  wire logic              i_in_call,
    // output channel
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [1:0]             o_result_kind,
    output logic [7:0]             o_control_byte,
    output logic                   o_strip_marker,
    output logic [11:0]            o_dac_sample,
    output logic                   o_dropped_oldest,
    output logic [FILL_W-1:0]      o_buffer_fill
);

    // Configuration registers. The fade weight is saturated at write time.
    logic [12:0] r_start_thr;
    logic [12:0] r_max_occ;
    logic [8:0]  r_fade_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_thr <= START_THR_RST;
            r_max_occ   <= MAX_OCC_RST;
            r_fade_k    <= FADE_KEEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_START_THR: r_start_thr <= i_cfg_data[12:0];
                CFG_MAX_OCC:   r_max_occ   <= i_cfg_data[12:0];
                CFG_FADE_KEEP: r_fade_k    <= (i_cfg_data[8:0] > FADE_FULL) ?
                                              FADE_FULL : i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Handshake between the two stages and the output register.
    logic r_s2_valid;
    logic r_out_valid;
    logic s2_move;
    logic in_accept;

    assign s2_move    = r_s2_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s2_valid || s2_move;
    assign in_accept  = i_in_valid && o_in_ready;

    // Stage one: framing state, pointers and fill count.
    logic [7:0]        r_win [4];
    logic              r_after;
    logic              r_collect;
    logic [15:0]       r_pend;
    logic [15:0]       r_left;
    logic [ADDR_W-1:0] r_wp;
    logic [ADDR_W-1:0] r_rp;
    logic [ADDR_W-1:0] r_fill;

    logic [7:0]        n_win [4];
    logic              n_after;
    logic              n_collect;
    logic [15:0]       n_pend;
    logic [15:0]       n_left;
    logic [ADDR_W-1:0] n_wp;
    logic [ADDR_W-1:0] n_rp;
    logic [ADDR_W-1:0] n_fill;

    logic              mem_we;
    logic              mem_re;
    t_s2               s1;
    logic [ADDR_W-1:0] fill_w;
    logic [3:0]        digit;

    assign digit = i_rx_byte[3:0] & NIBBLE_MASK;

    always_comb begin
        n_win     = r_win;
        n_after   = r_after;
        n_collect = r_collect;
        n_pend    = r_pend;
        n_left    = r_left;
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_fill    = r_fill;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        fill_w    = (r_fill == ADDR_W'(STORE_DEPTH - 1)) ? '0 : r_fill + ADDR_W'(1);
        s1.kind    = KIND_SILENT;
        s1.ctrl    = '0;
        s1.strip   = 1'b0;
        s1.smode   = SMP_MID;
        s1.dropped = 1'b0;

        if (i_func) begin
            s1.kind = KIND_SAMPLE;
            if (i_in_call) begin
                if (CMP_W'(r_fill) > CMP_W'(r_start_thr)) begin
                    mem_re   = 1'b1;
                    s1.smode = SMP_STORE;
                    n_rp     = ptr_inc(r_rp);
                    n_fill   = r_fill - ADDR_W'(1);
                end else begin
                    s1.smode = SMP_FADE;
                end
            end
        end else if (r_left != 16'd0) begin
            if (i_in_call) begin
                // Write, then enforce the latency cap on the new occupancy.
                mem_we = 1'b1;
                n_wp   = ptr_inc(r_wp);
                if (CMP_W'(fill_w) > CMP_W'(r_max_occ)) begin
                    n_rp       = ptr_inc(r_rp);
                    n_fill     = fill_w - ADDR_W'(1);
                    s1.dropped = 1'b1;
                end else begin
                    n_fill = fill_w;
                end
            end else begin
                s1.kind = KIND_CTRL;
                s1.ctrl = i_rx_byte;
            end
            n_left = r_left - 16'd1;
        end else if (r_after) begin
            n_after = 1'b0;
            if (i_rx_byte == CH_COMMA) begin
                n_collect = 1'b1;
                n_pend    = '0;
            end else if (is_digit(i_rx_byte)) begin
                n_collect = 1'b1;
                n_pend    = 16'(digit);
            end
        end else if (r_collect) begin
            if (is_digit(i_rx_byte)) begin
                n_pend = {r_pend[12:0], 3'b000} + {r_pend[14:0], 1'b0} + 16'(digit);
            end else if (i_rx_byte == CH_LF || i_rx_byte == CH_COLON) begin
                n_left    = r_pend;
                n_pend    = '0;
                n_collect = 1'b0;
            end else if (i_rx_byte != CH_CR) begin
                n_collect = 1'b0;
                n_pend    = '0;
            end
        end else begin
            s1.kind  = KIND_CTRL;
            s1.ctrl  = i_rx_byte;
            n_win[0] = r_win[1];
            n_win[1] = r_win[2];
            n_win[2] = r_win[3];
            n_win[3] = i_rx_byte;
            if (r_win[1] == CH_PLUS && r_win[2] == CH_I && r_win[3] == CH_P &&
                i_rx_byte == CH_D) begin
                s1.strip = 1'b1;
                n_after  = 1'b1;
            end
        end
        s1.fill = FILL_W'(n_fill);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win     <= '{default: '0};
            r_after   <= 1'b0;
            r_collect <= 1'b0;
            r_pend    <= '0;
            r_left    <= '0;
            r_wp      <= '0;
            r_rp      <= '0;
            r_fill    <= '0;
        end else if (in_accept) begin
            r_win     <= n_win;
            r_after   <= n_after;
            r_collect <= n_collect;
            r_pend    <= n_pend;
            r_left    <= n_left;
            r_wp      <= n_wp;
            r_rp      <= n_rp;
            r_fill    <= n_fill;
        end
    end

    // Audio store. The read port holds its data until the next read, and a
    // new read is only issued when stage two is empty or hands its beat on.
    logic [7:0] mem_rdata;

    pdjb_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (8),
        .AW    (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_accept && mem_we),
        .i_waddr (r_wp),
        .i_wdata (i_rx_byte),
        .i_re    (in_accept && mem_re),
        .i_raddr (r_rp),
        .o_rdata (mem_rdata)
    );

    // Stage two: sample generation and the output register.
    t_s2         r_s2;
    logic [11:0] r_last;
    logic [11:0] n_last;
    logic [20:0] fade_prod;
    logic [21:0] fade_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (in_accept) begin
            r_s2_valid <= 1'b1;
        end else if (s2_move) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s2 <= s1;
        end
    end

    assign fade_prod = 21'(r_last) * 21'(r_fade_k);
    assign fade_sum  = 22'(fade_prod) + {2'b00, 9'(FADE_FULL - r_fade_k), 11'd0};

    always_comb begin
        case (r_s2.smode)
            SMP_STORE: n_last = {mem_rdata, 4'h0};
            SMP_FADE:  n_last = fade_sum[19:8];
            default:   n_last = MID_LEVEL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= MID_LEVEL;
        end else if (s2_move && r_s2.kind == KIND_SAMPLE) begin
            r_last <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            o_result_kind    <= r_s2.kind;
            o_control_byte   <= r_s2.ctrl;
            o_strip_marker   <= r_s2.strip;
            o_dac_sample     <= (r_s2.kind == KIND_SAMPLE) ? n_last : 12'd0;
            o_dropped_oldest <= r_s2.dropped;
            o_buffer_fill    <= r_s2.fill;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ sv/pdjb_checker.sv @@
// Port-level checker for the payload deframer and jitter buffer, bound to it.
// Depends on pdjb_pkg.
`default_nettype none

module pdjb_checker
    import pdjb_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire logic [1:0]        o_result_kind,
    input wire logic [7:0]        o_control_byte,
    input wire logic              o_strip_marker,
    input wire logic [11:0]       o_dac_sample,
    input wire logic              o_dropped_oldest,
    input wire logic [FILL_W-1:0] o_buffer_fill
);

    // A stalled output beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result_kind) &&
        $stable(o_buffer_fill) && $stable(o_dac_sample))
        else $error("output beat changed while stalled");

    // Only control beats carry a byte or a strip flag.
    a_ctrl_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind != KIND_CTRL |-> o_control_byte == 8'd0 &&
        !o_strip_marker)
        else $error("control fields set on a non-control beat");

    // Only sample beats carry a sample, and a drop happens only on a stored byte.
    a_sample_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind != KIND_SAMPLE |-> o_dac_sample == 12'd0)
        else $error("sample set on a non-sample beat");

    a_drop_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_dropped_oldest |-> o_result_kind == KIND_SILENT)
        else $error("drop flagged on a beat that stored no byte");

endmodule

bind payload_deframer_jitter_buffer pdjb_checker u_pdjb_checker (.*);

`default_nettype wire

@@ tb/payload_deframer_jitter_buffer_test.sv @@
// Self-checking testbench for payload_deframer_jitter_buffer.
// Uses pdjb_pkg for store geometry, register indexes, characters and result kinds.
// Needs only the RTL; all stimulus and expected beats are generated in this file.
`default_nettype none

module payload_deframer_jitter_buffer_test;
    import pdjb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;
    localparam int   CYCLE_LIMIT = 200000;
    localparam int   HOLD_CYCLES = 250;

    // One beat on the input channel: a modem byte or a playback tick.
    typedef struct packed {
        logic       func;
        logic [7:0] rx;
        logic       call;
    } t_modem_beat;

    // One beat on the output channel, field for field.
    typedef struct packed {
        t_kind             kind;
        logic [7:0]        ctrl;
        logic              strip;
        logic [11:0]       sample;
        logic              dropped;
        logic [FILL_W-1:0] fill;
    } t_deframe_out;

    // Clock, reset and every block input start at a known value.
    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [1:0]       cfg_index = CFG_START_THR;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_func = FUNC_BYTE;
    logic [7:0]       in_byte = 8'h00;
    logic             in_call = 1'b0;
    logic             out_ready = 1'b0;

    logic              o_in_ready;
    logic              o_out_valid;
    logic [1:0]        o_result_kind;
    logic [7:0]        o_control_byte;
    logic              o_strip_marker;
    logic [11:0]       o_dac_sample;
    logic              o_dropped_oldest;
    logic [FILL_W-1:0] o_buffer_fill;

    payload_deframer_jitter_buffer DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_func           (in_func),
        .i_rx_byte        (in_byte),
        .i_in_call        (in_call),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_result_kind    (o_result_kind),
        .o_control_byte   (o_control_byte),
        .o_strip_marker   (o_strip_marker),
        .o_dac_sample     (o_dac_sample),
        .o_dropped_oldest (o_dropped_oldest),
        .o_buffer_fill    (o_buffer_fill)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Beats waiting to be sent, and output beats owed by the block in order.
    t_modem_beat  modem_beats[$];
    t_deframe_out owed_outputs[$];

    int  beats_offered = 0;
    int  beats_in = 0;
    int  results_seen = 0;
    int  fault_count = 0;
    int  cycles = 0;
    logic in_fire = 1'b0;
    logic hold_done = 1'b0;
    int  hold_left = 0;

    // Shadow copy of the block: framing state, ring, playback level and registers.
    logic [31:0]       marker_win;
    logic              after_mark;
    logic              in_length;
    logic [15:0]       length_acc;
    logic [15:0]       bytes_left;
    logic [7:0]        ring [STORE_DEPTH];
    logic [ADDR_W-1:0] wr_ptr;
    logic [ADDR_W-1:0] rd_ptr;
    logic [11:0]       level;
    logic [12:0]       thr_cfg;
    logic [12:0]       cap_cfg;
    logic [8:0]        keep_cfg;

    t_modem_beat  seen_beat;
    t_deframe_out seen_out;
    t_deframe_out want_out;

    // Works out the output beat for one input beat and advances the shadow state.
    // A tick in a call reads the ring once occupancy passes the threshold and
    // otherwise fades the level toward mid-scale; outside a call it snaps to
    // mid-scale. A payload byte in a call goes into the ring and may push the
    // oldest byte out; outside a call it is handed on as a control byte.
    function automatic t_deframe_out deframe_and_play(input t_modem_beat bt);
        t_deframe_out      r;
        logic [FILL_W-1:0] occ;
        int unsigned       k;
        int unsigned       mix;
        r = '0;
        r.kind = KIND_SILENT;
        if (bt.func == FUNC_TICK) begin
            r.kind = KIND_SAMPLE;
            if (bt.call) begin
                occ = wr_ptr - rd_ptr;
                if (occ > thr_cfg) begin
                    level = {ring[rd_ptr], 4'h0};
                    rd_ptr = rd_ptr + 1'b1;
                end else begin
                    k = (keep_cfg > FADE_FULL) ? 256 : keep_cfg;
                    mix = level * k + MID_LEVEL * (256 - k);
                    level = mix[19:8];
                end
            end else begin
                level = MID_LEVEL;
            end
            r.sample = level;
        end else if (bytes_left != 16'd0) begin
            if (bt.call) begin
                ring[wr_ptr] = bt.rx;
                wr_ptr = wr_ptr + 1'b1;
                occ = wr_ptr - rd_ptr;
                if (occ > cap_cfg) begin
                    rd_ptr = rd_ptr + 1'b1;
                    r.dropped = 1'b1;
                end
            end else begin
                r.kind = KIND_CTRL;
                r.ctrl = bt.rx;
            end
            bytes_left = bytes_left - 16'd1;
        end else if (after_mark) begin
            // Only a comma or a first digit opens the length field.
            after_mark = 1'b0;
            if (bt.rx == CH_COMMA) begin
                in_length = 1'b1;
                length_acc = 16'd0;
            end else if (bt.rx >= CH_ZERO && bt.rx <= CH_NINE) begin
                in_length = 1'b1;
                length_acc = {12'h000, 4'(bt.rx - CH_ZERO)};
            end
        end else if (in_length) begin
            if (bt.rx >= CH_ZERO && bt.rx <= CH_NINE) begin
                length_acc = length_acc * 16'd10 + {8'h00, bt.rx - CH_ZERO};
            end else if (bt.rx == CH_LF || bt.rx == CH_COLON) begin
                bytes_left = length_acc;
                length_acc = 16'd0;
                in_length = 1'b0;
            end else if (bt.rx != CH_CR) begin
                in_length = 1'b0;
                length_acc = 16'd0;
            end
        end else begin
            r.kind = KIND_CTRL;
            r.ctrl = bt.rx;
            marker_win = {marker_win[23:0], bt.rx};
            if (marker_win == {CH_PLUS, CH_I, CH_P, CH_D}) begin
                r.strip = 1'b1;
                after_mark = 1'b1;
            end
        end
        r.fill = wr_ptr - rd_ptr;
        return r;
    endfunction

    task automatic note_fault(input string msg);
        if (fault_count < 10) $display("%s", msg);
        fault_count++;
    endtask

    // Random idling on either side, switched off over a long stretch of beats.
    function automatic bit idle_roll(input int count);
        if (count >= 450 && count < 650) return 1'b0;
        return $urandom_range(99) < 9;
    endfunction

    // Monitor: samples both channels at the rising edge. The check of an
    // output beat runs before the prediction of a new input beat; a beat passes through
    // the stage-two and output registers first, so the order never matters for a match.
    always @(posedge clk) begin
        in_fire <= rst_n && in_valid && o_in_ready;
        if (!rst_n) begin
            marker_win = '0;
            after_mark = 1'b0;
            in_length = 1'b0;
            length_acc = '0;
            bytes_left = '0;
            wr_ptr = '0;
            rd_ptr = '0;
            level = MID_LEVEL;
            thr_cfg = START_THR_RST;
            cap_cfg = MAX_OCC_RST;
            keep_cfg = FADE_KEEP_RST;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_START_THR: thr_cfg = cfg_data;
                    CFG_MAX_OCC:   cap_cfg = cfg_data;
                    CFG_FADE_KEEP: keep_cfg = cfg_data[8:0];
                    default: ;
                endcase
            end
            if (o_out_valid && out_ready) begin
                results_seen++;
                seen_out.kind = t_kind'(o_result_kind);
                seen_out.ctrl = o_control_byte;
                seen_out.strip = o_strip_marker;
                seen_out.sample = o_dac_sample;
                seen_out.dropped = o_dropped_oldest;
                seen_out.fill = o_buffer_fill;
                if (owed_outputs.size() == 0) begin
                    note_fault($sformatf("%0t: output beat with nothing owed: kind=%0d ctrl=%h",
                        $realtime, o_result_kind, o_control_byte));
                end else begin
                    want_out = owed_outputs.pop_front();
                    if (seen_out.kind !== want_out.kind || seen_out.ctrl !== want_out.ctrl ||
                        seen_out.strip !== want_out.strip ||
                        seen_out.sample !== want_out.sample ||
                        seen_out.dropped !== want_out.dropped ||
                        seen_out.fill !== want_out.fill) begin
                        note_fault($sformatf({"%0t: output beat %0d mismatch:",
                            " got kind=%0d ctrl=%h strip=%b sample=%h drop=%b fill=%0d,",
                            " expected kind=%0d ctrl=%h strip=%b sample=%h drop=%b fill=%0d"},
                            $realtime, results_seen, seen_out.kind, seen_out.ctrl,
                            seen_out.strip, seen_out.sample, seen_out.dropped, seen_out.fill,
                            want_out.kind, want_out.ctrl, want_out.strip, want_out.sample,
                            want_out.dropped, want_out.fill));
                    end
                end
            end
            if (in_valid && o_in_ready) begin
                seen_beat.func = in_func;
                seen_beat.rx = in_byte;
                seen_beat.call = in_call;
                owed_outputs.push_back(deframe_and_play(seen_beat));
                beats_in++;
            end
        end
    end

    // Driver: presents the next queued beat at the falling edge once the
    // previous one has been taken, or leaves a random gap.
    always @(negedge clk) begin : drive_beat
        t_modem_beat nb;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fire) begin
            if (modem_beats.size() != 0 && !idle_roll(beats_in)) begin
                nb = modem_beats.pop_front();
                in_valid <= 1'b1;
                in_func <= nb.func;
                in_byte <= nb.rx;
                in_call <= nb.call;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off while the sender still
    // has plenty queued, so that both pipeline stages fill and input ready drops.
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (!hold_done && results_seen >= 300 && modem_beats.size() > 20) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else begin
            out_ready <= !idle_roll(results_seen);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic offer(input logic f, input logic [7:0] b, input logic c);
        t_modem_beat nb;
        nb.func = f;
        nb.rx = b;
        nb.call = c;
        modem_beats.push_back(nb);
        beats_offered++;
    endtask

    task automatic offer_marker();
        offer(FUNC_BYTE, CH_PLUS, 1'($urandom_range(1)));
        offer(FUNC_BYTE, CH_I, 1'($urandom_range(1)));
        offer(FUNC_BYTE, CH_P, 1'($urandom_range(1)));
        offer(FUNC_BYTE, CH_D, 1'($urandom_range(1)));
    endtask

    // A well-formed frame with random content: marker, comma or first digit,
    // length (sometimes past 65535 so it wraps, sometimes with carriage
    // returns), terminator, then the payload with ticks mixed in.
    task automatic offer_frame();
        logic [7:0] digs[$];
        logic       call;
        int         len;
        int         v;
        call = ($urandom_range(9) < 8);
        len = ($urandom_range(7) == 0) ? $urandom_range(60, 13) : $urandom_range(12);
        v = len + (($urandom_range(9) == 0) ? 65536 * $urandom_range(1, 3) : 0);
        do begin
            digs.push_front(8'(CH_ZERO + v % 10));
            v = v / 10;
        end while (v != 0);
        offer_marker();
        if ($urandom_range(1)) begin
            offer(FUNC_BYTE, CH_COMMA, call);
            // A bare comma and terminator is also a zero length.
            if (digs.size() == 1 && digs[0] == CH_ZERO && $urandom_range(1)) digs.delete();
        end
        foreach (digs[i]) begin
            offer(FUNC_BYTE, digs[i], call);
            if ($urandom_range(7) == 0) offer(FUNC_BYTE, CH_CR, call);
        end
        offer(FUNC_BYTE, $urandom_range(1) ? CH_LF : CH_COLON, call);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 30) offer(FUNC_TICK, 8'($urandom), call);
            offer(FUNC_BYTE, 8'($urandom), call);
        end
    endtask

    task automatic offer_traffic(input int count);
        int target;
        int pick;
        target = beats_offered + count;
        while (beats_offered < target) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                offer_frame();
            end else if (pick < 80) begin
                repeat ($urandom_range(4, 1))
                    offer(FUNC_TICK, 8'($urandom), $urandom_range(9) < 8);
            end else if (pick < 90) begin
                repeat ($urandom_range(3, 1))
                    offer(FUNC_BYTE, 8'($urandom), 1'($urandom_range(1)));
            end else begin
                // Broken frame: junk after the marker, or a letter inside the length.
                offer_marker();
                if ($urandom_range(1)) begin
                    offer(FUNC_BYTE, 8'($urandom), 1'($urandom_range(1)));
                end else begin
                    offer(FUNC_BYTE, CH_COMMA, 1'b1);
                    repeat ($urandom_range(3, 1))
                        offer(FUNC_BYTE, 8'(CH_ZERO + $urandom_range(9)), 1'b1);
                    offer(FUNC_BYTE, 8'($urandom_range(8'h5A, 8'h41)), 1'b1);
                end
            end
        end
    endtask

    // Registers are only written with nothing in flight.
    task automatic write_settings(input logic [12:0] thr, input logic [12:0] cap,
                                  input logic [8:0] keep);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_START_THR;
        cfg_data <= thr;
        @(negedge clk);
        cfg_index <= CFG_MAX_OCC;
        cfg_data <= cap;
        @(negedge clk);
        cfg_index <= CFG_FADE_KEEP;
        cfg_data <= CFG_W'(keep);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Every beat yields exactly one output beat, so an empty owed list with
    // nothing queued or on the wire means the block is idle.
    task automatic wait_drained();
        while (modem_beats.size() != 0 || in_valid || owed_outputs.size() != 0)
            @(posedge clk);
    endtask

    initial begin : run_test
        logic [12:0] thr;
        logic [12:0] cap;
        logic [8:0]  keep;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, with a fade weight above full scale and a cap of one.
        write_settings(13'd0, 13'd1, 9'd300);
        offer(FUNC_TICK, 8'hFF, 1'b0);              // leaving a call: mid-scale
        offer_marker();
        offer(FUNC_BYTE, 8'hFF, 1'b1);              // junk after the marker
        offer_marker();
        offer(FUNC_BYTE, CH_COMMA, 1'b0);
        offer(FUNC_BYTE, CH_COLON, 1'b0);           // zero length
        offer_marker();
        offer(FUNC_BYTE, CH_NINE, 1'b0);
        offer(FUNC_BYTE, 8'h71, 1'b0);              // letter inside the length
        offer_marker();
        offer(FUNC_BYTE, 8'h36, 1'b1);              // 65539 wraps to a length of 3
        offer(FUNC_BYTE, 8'h35, 1'b1);
        offer(FUNC_BYTE, 8'h35, 1'b1);
        offer(FUNC_BYTE, CH_CR, 1'b1);
        offer(FUNC_BYTE, 8'h33, 1'b1);
        offer(FUNC_BYTE, CH_NINE, 1'b1);
        offer(FUNC_BYTE, CH_LF, 1'b1);
        offer(FUNC_BYTE, 8'h00, 1'b0);              // payload outside a call
        offer(FUNC_BYTE, 8'hA5, 1'b1);
        offer(FUNC_BYTE, 8'h5A, 1'b1);              // second write passes the cap
        offer(FUNC_TICK, 8'h00, 1'b1);              // reads the ring
        offer(FUNC_TICK, 8'hFF, 1'b1);              // empty ring, saturated fade holds
        wait_drained();

        // Random phases over a range of settings, extremes included.
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin thr = START_THR_RST; cap = MAX_OCC_RST; keep = FADE_KEEP_RST; end
                1: begin thr = 13'd0; cap = 13'd8191; keep = 9'd0; end
                2: begin thr = 13'd8191; cap = 13'd0; keep = FADE_FULL; end
                3: begin thr = 13'd3; cap = 13'd24; keep = 9'd128; end
                4: begin
                    thr = 13'($urandom_range(12));
                    cap = 13'($urandom_range(64));
                    keep = 9'($urandom_range(511));
                end
                default: begin thr = 13'd1; cap = 13'd8190; keep = 9'd511; end
            endcase
            write_settings(thr, cap, keep);
            offer_traffic(140);
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (owed_outputs.size() != 0)
            note_fault($sformatf("%0d output beats never arrived", owed_outputs.size()));
        if (fault_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
sv/pdjb_pkg.sv
sv/pdjb_ram.sv
sv/payload_deframer_jitter_buffer.sv
sv/pdjb_checker.sv
tb/payload_deframer_jitter_buffer_test.sv
